FILE: hdl/alu8f_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8f_pkg
// Shared types and constants for the 8-bit ALU with carry, zero and overflow
// flags.
// ----------------------------------------------------------------------------
package alu8f_pkg;

	localparam int unsigned DataWidth = 8;
	localparam int unsigned OpWidth   = 4;

	typedef logic [DataWidth-1:0] alu8f_data_t;

	typedef enum logic [OpWidth-1:0] {
		OP_ADD = 4'd0,
		OP_ADC = 4'd1,
		OP_SUB = 4'd2,
		OP_SBB = 4'd3,
		OP_AND = 4'd4,
		OP_OR  = 4'd5,
		OP_XOR = 4'd6,
		OP_INC = 4'd7,
		OP_DEC = 4'd8,
		OP_NOT = 4'd9,
		OP_SHL = 4'd10,
		OP_SHR = 4'd11
	} alu8f_op_t;

	localparam logic KIND_OPERATE    = 1'b0;
	localparam logic KIND_LOAD_FLAGS = 1'b1;

	typedef struct packed {
		logic overflow;
		logic zero;
		logic carry;
	} alu8f_flags_t;

endpackage

FILE: hdl/alu8f_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8f_core
// Combinational datapath: computes the result byte, the write enable and the
// next flag values for one request.
// ----------------------------------------------------------------------------
module alu8f_core
	import alu8f_pkg::*;
(
	input  logic         kind,
	input  logic [3:0]   opcode,
	input  alu8f_data_t  left_operand,
	input  alu8f_data_t  right_operand,
	input  alu8f_data_t  flag_data,
	input  alu8f_flags_t flags_cur,
	output alu8f_data_t  result,
	output logic         result_written,
	output alu8f_flags_t flags_next
);

	logic [DataWidth:0] lhs_w;
	logic [DataWidth:0] rhs_w;
	logic [DataWidth:0] c_w;
	logic [DataWidth:0] wide;
	logic               valid_op;
	logic               is_add;
	logic               is_sub;
	logic               s1;
	logic               s2;
	logic               sr;

	assign lhs_w = {1'b0, left_operand};
	assign rhs_w = {1'b0, right_operand};
	assign c_w   = {{DataWidth{1'b0}}, flags_cur.carry};

	always_comb begin
		wide     = '0;
		valid_op = 1'b1;
		is_add   = 1'b0;
		is_sub   = 1'b0;
		case (alu8f_op_t'(opcode))
			OP_ADD: begin
				wide   = lhs_w + rhs_w;
				is_add = 1'b1;
			end
			OP_ADC: begin
				wide   = lhs_w + rhs_w + c_w;
				is_add = 1'b1;
			end
			OP_SUB: begin
				wide   = lhs_w - rhs_w;
				is_sub = 1'b1;
			end
			OP_SBB: begin
				wide   = lhs_w - rhs_w - c_w;
				is_sub = 1'b1;
			end
			OP_AND: wide = lhs_w & rhs_w;
			OP_OR:  wide = lhs_w | rhs_w;
			OP_XOR: wide = lhs_w ^ rhs_w;
			OP_INC: wide = rhs_w + {{DataWidth{1'b0}}, 1'b1};
			OP_DEC: wide = rhs_w - {{DataWidth{1'b0}}, 1'b1};
			OP_NOT: wide = {1'b0, ~right_operand};
			OP_SHL: wide = {right_operand, flags_cur.carry};
			OP_SHR: wide = {right_operand[0], flags_cur.carry,
				right_operand[DataWidth-1:1]};
			default: valid_op = 1'b0;
		endcase
	end

	assign s1 = left_operand[DataWidth-1];
	assign s2 = right_operand[DataWidth-1];
	assign sr = wide[DataWidth-1];

	always_comb begin
		result         = '0;
		result_written = 1'b0;
		flags_next     = flags_cur;
		if (kind == KIND_LOAD_FLAGS) begin
			flags_next.carry    = flag_data[0];
			flags_next.zero     = flag_data[1];
			flags_next.overflow = flag_data[2];
		end else if (valid_op) begin
			result              = wide[DataWidth-1:0];
			result_written      = 1'b1;
			flags_next.carry    = wide[DataWidth];
			flags_next.zero     = (wide[DataWidth-1:0] == '0);
			flags_next.overflow = (is_add & ~(s1 ^ s2) & (sr ^ s1)) |
				(is_sub & (s1 ^ s2) & (sr ^ s1));
		end
	end

endmodule

FILE: hdl/alu_8bit_with_flags_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_8bit_with_flags_top
// 8-bit ALU with carry, zero and overflow flags, one request per clock while not stalled.
// ----------------------------------------------------------------------------
// Each request is captured in an input register, evaluated against the flag
// register and written to an output register together with the updated flags.
// A result moves from the input register to the output register once the
// output register is free. One request is accepted every cycle while the
// input is not stalled; the carry feeds back from the flag register to
// the datapath. While a finished result waits to be taken, an empty input
// register takes one more request and then the input stalls until taken.
// ----------------------------------------------------------------------------
module alu_8bit_with_flags_top
	import alu8f_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [3:0]  opcode,
	input  logic [7:0]  left_operand,
	input  logic [7:0]  right_operand,
	input  logic [7:0]  flag_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  result,
	output logic        result_written,
	output logic        carry_out,
	output logic        zero_out,
	output logic        overflow_out
);

	logic         valid_s1;
	logic         kind_s1;
	logic [3:0]   opcode_s1;
	alu8f_data_t  lhs_s1;
	alu8f_data_t  rhs_s1;
	alu8f_data_t  fdata_s1;
	alu8f_flags_t flags_q;
	alu8f_flags_t flags_next;
	alu8f_data_t  core_result;
	logic         core_written;
	logic         out_free;
	logic         advance;
	logic         out_valid_q;
	alu8f_data_t  result_q;
	logic         written_q;
	alu8f_flags_t out_flags_q;

	assign out_free = ~out_valid_q | ~out_stall;
	assign advance  = valid_s1 & out_free;
	assign in_stall = valid_s1 & ~out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1   <= kind;
			opcode_s1 <= opcode;
			lhs_s1    <= left_operand;
			rhs_s1    <= right_operand;
			fdata_s1  <= flag_data;
		end
	end

	alu8f_core u_core (
		.kind           (kind_s1),
		.opcode         (opcode_s1),
		.left_operand   (lhs_s1),
		.right_operand  (rhs_s1),
		.flag_data      (fdata_s1),
		.flags_cur      (flags_q),
		.result         (core_result),
		.result_written (core_written),
		.flags_next     (flags_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				flags_q <= flags_next;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q    <= core_result;
			written_q   <= core_written;
			out_flags_q <= flags_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign result         = result_q;
	assign result_written = written_q;
	assign carry_out      = out_flags_q.carry;
	assign zero_out       = out_flags_q.zero;
	assign overflow_out   = out_flags_q.overflow;

endmodule
